FILE: src/life_like_automaton_engine_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef LIFE_LIKE_AUTOMATON_ENGINE_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_ENGINE_ASSERT_SVH

// A clocked assertion that is switched off while reset is high.
`define LLA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A clocked assertion that is also checked during reset.
`define LLA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lla_pkg.sv
`default_nettype none

package lla_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam int CFG_SIZE_W = 7;
   localparam int NBR_CODES  = 9;
   localparam int MASK_W     = NBR_CODES;
   localparam int CNT_W      = $clog2(NBR_CODES);
   localparam int CSR_DATA_W = 9;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;

   localparam logic [CFG_SIZE_W-1:0] ROWS_RESET = 7'd64;
   localparam logic [CFG_SIZE_W-1:0] COLS_RESET = 7'd64;
   localparam logic [MASK_W-1:0]     LIVE_RESET = 9'd8;
   localparam logic [MASK_W-1:0]     KEEP_RESET = 9'd4;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_STEP  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      REPLY_WRITE = 2'd0,
      REPLY_READ  = 2'd1,
      REPLY_STEP  = 2'd2
   } reply_kind_type;

   typedef enum logic [1:0] {
      CSR_ROWS = 2'd0,
      CSR_COLS = 2'd1,
      CSR_LIVE = 2'd2,
      CSR_KEEP = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL,
      ST_STEP_UP,
      ST_STEP_DN,
      ST_STEP_MID,
      ST_STEP_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      mode_type         mode;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             value;
   } req_payload_type;

   typedef struct packed {
      reply_kind_type reply_kind;
      logic           cell_value;
      logic           out_of_range;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: src/lla_ram.sv
`default_nettype none

module lla_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/life_like_automaton_engine.sv
// Life-like cellular automaton on a wrapping grid of one-bit cells.
// Request beats carry a mode (write cell, read cell, step), a row, a column
// and a value; every request beat yields exactly one response beat with the
// reply kind, the cell read and an out-of-range flag.
// The grid is kept as two banks of row words, one bit per column. A step
// reads the row above, the row below and the row itself from the current
// bank and writes the new row into the other bank, row by row over all
// MAX_ROWS rows: read the row above, the row below, the row, then write;
// then the banks swap. A cell read or write first reads the row, then the
// bit is picked or merged and written back. An out-of-range or unused
// request goes straight to its reply.
// One request is worked on at a time; req_stall is high while it is.
// The response sits in an output register, so a stalled response does not
// block work on the next request, whose reply waits until the register
// frees up. After reset both banks are cleared row by row, during which no
// request is taken; CSR writes are taken at any time and are meant to be
// made only while the block is idle.
`default_nettype none

module life_like_automaton_engine #(
   parameter int MAX_ROWS = lla_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = lla_pkg::DEF_MAX_COLS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire lla_pkg::req_payload_type             req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output lla_pkg::rsp_payload_type                  rsp_payload,
   input  wire logic                                 csr_wr_en,
   input  wire lla_pkg::csr_index_type               csr_index,
   input  wire logic [lla_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import lla_pkg::*;

   localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RSW = ($clog2(MAX_ROWS + 1) > CFG_SIZE_W) ? $clog2(MAX_ROWS + 1) : CFG_SIZE_W;
   localparam int CSW = ($clog2(MAX_COLS + 1) > CFG_SIZE_W) ? $clog2(MAX_COLS + 1) : CFG_SIZE_W;

   state_type             state_ff, state_in;
   logic [RAW-1:0]        row_ff, row_in;
   logic                  bank_ff, bank_in;
   logic [CFG_SIZE_W-1:0] rows_ff, rows_in;
   logic [CFG_SIZE_W-1:0] cols_ff, cols_in;
   logic [MASK_W-1:0]     live_ff, live_in;
   logic [MASK_W-1:0]     keep_ff, keep_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   req_payload_type       item_ff, item_in;
   rsp_payload_type       res_ff, res_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;
   logic [MAX_COLS-1:0]   up_word_ff, up_word_in;
   logic [MAX_COLS-1:0]   dn_word_ff, dn_word_in;

   logic [RAW-1:0]        ram_rd_addr;
   logic [RAW-1:0]        ram_wr_addr;
   logic [MAX_COLS-1:0]   ram_wdata;
   logic                  ram_we_a;
   logic                  ram_we_b;
   logic [MAX_COLS-1:0]   rd_a;
   logic [MAX_COLS-1:0]   rd_b;
   logic [MAX_COLS-1:0]   src_word;
   logic [MAX_COLS-1:0]   next_word;

   logic [RSW-1:0]        rows_ext;
   logic [CSW-1:0]        cols_ext;
   logic [RSW-1:0]        nr;
   logic [CSW-1:0]        nc;
   logic [CAW-1:0]        nc_last;
   logic                  req_oor;
   logic                  row_used;
   logic [RAW-1:0]        up_row;
   logic [RAW-1:0]        dn_row;
   logic [CAW-1:0]        cell_col;
   logic                  rsp_free;

   lla_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid_a (
      .clock   (clock),
      .wr_en   (ram_we_a),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wdata),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_a)
   );

   lla_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid_b (
      .clock   (clock),
      .wr_en   (ram_we_b),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wdata),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_b)
   );

   assign src_word = bank_ff ? rd_b : rd_a;

   // Sizes in use are clamped to one up to the grid size.
   assign rows_ext = RSW'(rows_ff);
   assign cols_ext = CSW'(cols_ff);
   assign nr = (rows_ext == '0) ? RSW'(1) :
               (rows_ext > RSW'(MAX_ROWS)) ? RSW'(MAX_ROWS) : rows_ext;
   assign nc = (cols_ext == '0) ? CSW'(1) :
               (cols_ext > CSW'(MAX_COLS)) ? CSW'(MAX_COLS) : cols_ext;
   assign nc_last = CAW'(nc - CSW'(1));

   assign req_oor = (RSW'(req_payload.row) >= nr) || (CSW'(req_payload.col) >= nc);

   assign row_used = RSW'(row_ff) < nr;
   assign up_row = !row_used ? row_ff :
                   (row_ff == '0) ? RAW'(nr - RSW'(1)) : row_ff - RAW'(1);
   assign dn_row = !row_used ? row_ff :
                   ((RSW'(row_ff) + RSW'(1)) == nr) ? '0 : row_ff + RAW'(1);

   assign cell_col = CAW'(item_ff.col);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
      logic             lf_u, lf_m, lf_d;
      logic             rt_u, rt_m, rt_d;
      logic             col_used;
      logic [CNT_W-1:0] cnt;

      if (c == 0) begin : g_left_wrap
         assign lf_u = up_word_ff[nc_last];
         assign lf_m = src_word[nc_last];
         assign lf_d = dn_word_ff[nc_last];
      end else begin : g_left
         assign lf_u = up_word_ff[c-1];
         assign lf_m = src_word[c-1];
         assign lf_d = dn_word_ff[c-1];
      end

      if (c == MAX_COLS - 1) begin : g_right_wrap
         assign rt_u = up_word_ff[0];
         assign rt_m = src_word[0];
         assign rt_d = dn_word_ff[0];
      end else begin : g_right
         logic rt_wrap;
         assign rt_wrap = (CSW'(c + 1) == nc);
         assign rt_u = rt_wrap ? up_word_ff[0] : up_word_ff[c+1];
         assign rt_m = rt_wrap ? src_word[0]   : src_word[c+1];
         assign rt_d = rt_wrap ? dn_word_ff[0] : dn_word_ff[c+1];
      end

      assign col_used = CSW'(c) < nc;
      assign cnt = CNT_W'(lf_u) + CNT_W'(up_word_ff[c]) + CNT_W'(rt_u)
                 + CNT_W'(lf_m) + CNT_W'(rt_m)
                 + CNT_W'(lf_d) + CNT_W'(dn_word_ff[c]) + CNT_W'(rt_d);
      assign next_word[c] = !(row_used && col_used) ? src_word[c] :
                            live_ff[cnt] ? 1'b1 :
                            keep_ff[cnt] ? src_word[c] : 1'b0;
   end

   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      bank_in        = bank_ff;
      rows_in        = rows_ff;
      cols_in        = cols_ff;
      live_in        = live_ff;
      keep_in        = keep_ff;
      item_in        = item_ff;
      res_in         = res_ff;
      up_word_in     = up_word_ff;
      dn_word_in     = dn_word_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      ram_rd_addr    = row_ff;
      ram_wr_addr    = row_ff;
      ram_wdata      = next_word;
      ram_we_a       = 1'b0;
      ram_we_b       = 1'b0;
      req_stall      = (state_ff != ST_IDLE);

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = csr_wdata[CFG_SIZE_W-1:0];
            CSR_COLS: cols_in = csr_wdata[CFG_SIZE_W-1:0];
            CSR_LIVE: live_in = csr_wdata[MASK_W-1:0];
            CSR_KEEP: keep_in = csr_wdata[MASK_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wdata = '0;
            ram_we_a  = 1'b1;
            ram_we_b  = 1'b1;
            if (row_ff == RAW'(MAX_ROWS - 1)) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + RAW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_payload;
               unique case (req_payload.mode) inside
                  MODE_WRITE, MODE_READ: begin
                     res_in.reply_kind   = (req_payload.mode == MODE_READ) ?
                                           REPLY_READ : REPLY_WRITE;
                     res_in.cell_value   = 1'b0;
                     res_in.out_of_range = req_oor;
                     ram_rd_addr         = RAW'(req_payload.row);
                     state_in            = req_oor ? ST_FINISH : ST_CELL;
                  end
                  MODE_STEP: begin
                     row_in   = '0;
                     state_in = ST_STEP_UP;
                  end
                  default: begin
                     res_in   = '{reply_kind: REPLY_WRITE, cell_value: 1'b0,
                                  out_of_range: 1'b1};
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_CELL: begin
            if (item_ff.mode == MODE_READ) begin
               res_in.cell_value = src_word[cell_col];
            end else begin
               ram_wr_addr           = RAW'(item_ff.row);
               ram_wdata             = src_word;
               ram_wdata[cell_col]   = item_ff.value;
               ram_we_a              = !bank_ff;
               ram_we_b              = bank_ff;
            end
            state_in = ST_FINISH;
         end
         ST_STEP_UP: begin
            ram_rd_addr = up_row;
            state_in    = ST_STEP_DN;
         end
         ST_STEP_DN: begin
            up_word_in  = src_word;
            ram_rd_addr = dn_row;
            state_in    = ST_STEP_MID;
         end
         ST_STEP_MID: begin
            dn_word_in  = src_word;
            ram_rd_addr = row_ff;
            state_in    = ST_STEP_WR;
         end
         ST_STEP_WR: begin
            ram_we_a = bank_ff;
            ram_we_b = !bank_ff;
            if (row_ff == RAW'(MAX_ROWS - 1)) begin
               row_in   = '0;
               bank_in  = !bank_ff;
               res_in   = '{reply_kind: REPLY_STEP, cell_value: 1'b0,
                            out_of_range: 1'b0};
               state_in = ST_FINISH;
            end else begin
               row_in   = row_ff + RAW'(1);
               state_in = ST_STEP_UP;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         bank_ff      <= 1'b0;
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLS_RESET;
         live_ff      <= LIVE_RESET;
         keep_ff      <= KEEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         bank_ff      <= bank_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         live_ff      <= live_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      res_ff         <= res_in;
      up_word_ff     <= up_word_in;
      dn_word_ff     <= dn_word_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

FILE: src/lla_checker.sv
`default_nettype none

`include "life_like_automaton_engine_assert.svh"

module lla_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire lla_pkg::rsp_payload_type       rsp_payload
);

   import lla_pkg::*;

   // A stalled response beat stays in place.
   `LLA_ASSERT(rsp_hold_a, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "Stalled response beat changed.")

   // Only one request is in work, so a taken beat closes the request side.
   `LLA_ASSERT(busy_after_accept_a, clock, reset, req_valid && !req_stall |=> req_stall, "Request taken while another is in work.")

   `LLA_ASSERT(step_reply_clean_a, clock, reset, rsp_valid && (rsp_payload.reply_kind == REPLY_STEP) |-> !rsp_payload.cell_value && !rsp_payload.out_of_range, "Step reply carries a cell or a flag.")

   `LLA_ASSERT(cell_only_on_read_a, clock, reset, rsp_valid && (rsp_payload.reply_kind != REPLY_READ) |-> !rsp_payload.cell_value, "Cell value on a reply that is not a read.")

   `LLA_ASSERT_ALWAYS(no_rsp_after_reset_a, clock, $fell(reset) |-> !rsp_valid && req_stall, "Response or request open right after reset.")

endmodule

bind life_like_automaton_engine lla_checker u_lla_checker (.*);

`default_nettype wire
